[rtl/core/sync_header_length_deframer_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sync header length deframer
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_LENGTH_DEFRAMER_TOP_DEFINES_SVH
`define SYNC_HEADER_LENGTH_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define SHLD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/shld_pkg.sv]
// ----------------------------------------------------------------------------
// shld_pkg
// Constants and types shared by the deframer top level and its header hunter.
// ----------------------------------------------------------------------------
package shld_pkg;

	// Header layout
	localparam int HEADER_BYTES = 10;
	localparam int WIN_DEPTH    = HEADER_BYTES - 1;
	localparam int CODE_SLOT    = 5;
	localparam int LEN_LO_SLOT  = 6;
	localparam int LEN_HI_SLOT  = 7;

	localparam logic [7:0] SYNC_A = 8'h68;
	localparam logic [7:0] SYNC_B = 8'hFF;

	// Header match result from the hunter
	typedef struct packed {
		logic        hit;
		logic [7:0]  code;
		logic [15:0] length;
	} hunt_res_t;

endpackage

[rtl/core/shld_hunt.sv]
// ----------------------------------------------------------------------------
// shld_hunt
// Sync window and header match: holds the last bytes seen while hunting.
// ----------------------------------------------------------------------------
module shld_hunt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	output shld_pkg::hunt_res_t res
);

	logic [7:0] win_q [shld_pkg::WIN_DEPTH];
	logic [7:0] slot  [shld_pkg::HEADER_BYTES];

	// Newest byte sits in the last slot
	always_comb begin
		for (int i = 0; i < shld_pkg::WIN_DEPTH; i++) begin
			slot[i] = win_q[i];
		end
		slot[shld_pkg::HEADER_BYTES-1] = byte_in;
	end

	always_comb begin
		res.hit = (slot[0] == shld_pkg::SYNC_A) && (slot[1] == shld_pkg::SYNC_A) &&
			(slot[2] == shld_pkg::SYNC_B) && (slot[3] == shld_pkg::SYNC_B) &&
			(slot[4] == shld_pkg::SYNC_B) &&
			(slot[8] == shld_pkg::SYNC_A) && (slot[9] == shld_pkg::SYNC_A);
		res.code   = slot[shld_pkg::CODE_SLOT];
		res.length = {slot[shld_pkg::LEN_HI_SLOT], slot[shld_pkg::LEN_LO_SLOT]};
	end

	// Clear on a hit, otherwise advance by one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < shld_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < shld_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= res.hit ? 8'h00 : slot[i+1];
			end
		end
	end

endmodule

[rtl/core/sync_header_length_deframer_top.sv]
// ----------------------------------------------------------------------------
// sync_header_length_deframer_top
// Pulls length-prefixed frames out of a byte stream and streams the payload.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_in) carries one received
//   byte per transaction. Result channel (result_valid / result_stall and
//   the payload fields) carries one payload byte per transaction with its
//   index, the frame code, the frame length and a last flag.
//   While hunting, bytes fill a ten-byte sync window; a header produces no
//   transaction unless its length is zero, in which case one empty marker
//   (is_empty and is_last set) goes out. Payload bytes are never searched.
// Timing:
//   One byte per cycle while no held result is stalled. A byte is registered
//   on entry, decoded by the window compare and length counter, and its
//   result is registered on the output, so result_valid follows the entry
//   register via the result register; the compare and counter set the rate.
// Reset:
//   arst_n clears the window, the frame state and both valid flags; the
//   block hunts from an all-zero window.
// Stall:
//   A held result keeps its fields stable. The entry register still drains
//   bytes that give no result; otherwise byte_stall rises while it waits.
// ----------------------------------------------------------------------------
module sync_header_length_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [7:0]  frame_code,
	output logic [15:0] frame_length,
	output logic        is_last,
	output logic        is_empty
);

	// Entry register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Frame state
	logic        in_frame_q;
	logic [15:0] bytes_taken_q;
	logic [15:0] expected_length_q;
	logic [7:0]  latched_code_q;

	// Result register
	logic        result_valid_q;
	logic [7:0]  payload_byte_q;
	logic [15:0] payload_index_q;
	logic [7:0]  frame_code_q;
	logic [15:0] frame_length_q;
	logic        is_last_q;
	logic        is_empty_q;

	shld_pkg::hunt_res_t hunt;

	logic        empty_hit;
	logic        res_gen;
	logic        s1_go;
	logic        byte_take;
	logic        frame_last;
	logic [16:0] next_count;

	shld_hunt u_hunt (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_go && !in_frame_q),
		.byte_in (byte_s1),
		.res     (hunt)
	);

	// Decode the byte in the entry register
	always_comb begin
		empty_hit  = !in_frame_q && hunt.hit && (hunt.length == 16'd0);
		res_gen    = valid_s1 && (in_frame_q || empty_hit);
		// Bytes that produce no result never wait on the output side
		s1_go      = valid_s1 && (!res_gen || !result_valid_q || !result_stall);
		byte_stall = valid_s1 && !s1_go;
		byte_take  = byte_valid && !byte_stall;
		next_count = {1'b0, bytes_taken_q} + 17'd1;
		frame_last = next_count >= {1'b0, expected_length_q};
	end

	// Entry register: load on each transaction, drop when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_s1 <= byte_in;
		end
	end

	// Frame state: latch header, count payload, end frame on last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q        <= 1'b0;
			bytes_taken_q     <= '0;
			expected_length_q <= '0;
			latched_code_q    <= '0;
		end else if (s1_go) begin
			if (in_frame_q) begin
				if (frame_last) begin
					in_frame_q        <= 1'b0;
					bytes_taken_q     <= '0;
					expected_length_q <= '0;
				end else begin
					bytes_taken_q <= next_count[15:0];
				end
			end else if (hunt.hit) begin
				latched_code_q <= hunt.code;
				if (hunt.length != 16'd0) begin
					in_frame_q        <= 1'b1;
					expected_length_q <= hunt.length;
					bytes_taken_q     <= '0;
				end
			end
		end
	end

	// Result register: hold while stalled, release when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_go && res_gen) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_gen) begin
			if (in_frame_q) begin
				payload_byte_q  <= byte_s1;
				payload_index_q <= bytes_taken_q;
				frame_code_q    <= latched_code_q;
				frame_length_q  <= expected_length_q;
				is_last_q       <= frame_last;
				is_empty_q      <= 1'b0;
			end else begin
				payload_byte_q  <= 8'h00;
				payload_index_q <= 16'd0;
				frame_code_q    <= hunt.code;
				frame_length_q  <= 16'd0;
				is_last_q       <= 1'b1;
				is_empty_q      <= 1'b1;
			end
		end
	end

	assign result_valid  = result_valid_q;
	assign payload_byte  = payload_byte_q;
	assign payload_index = payload_index_q;
	assign frame_code    = frame_code_q;
	assign frame_length  = frame_length_q;
	assign is_last       = is_last_q;
	assign is_empty      = is_empty_q;

	`include "sync_header_length_deframer_top_defines.svh"

	`SHLD_ASSERT_NOW(a_empty_marker, result_valid_q && is_empty_q, is_last_q && (payload_index_q == 16'd0) && (frame_length_q == 16'd0), "empty marker fields wrong")
	`SHLD_ASSERT_NOW(a_count_bound, in_frame_q, bytes_taken_q < expected_length_q, "payload count past frame length")
	`SHLD_ASSERT_NOW(a_hunt_idle, !in_frame_q, (bytes_taken_q == 16'd0) && (expected_length_q == 16'd0), "frame counters not clear while hunting")
	`SHLD_ASSERT_NEXT(a_entry_hold, valid_s1 && !s1_go, valid_s1 && $stable(byte_s1), "entry byte lost while blocked")

endmodule
